@@ rtl/psf_pkg.sv @@
// Shared types, register indexes and the CORDIC arctangent table for the sector filter.
package psf_pkg;

	localparam int ANGLE_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int ACC_W      = 32;
	localparam int ATAN_DEPTH = 24;

	typedef logic [ANGLE_W-1:0]        angle_t;
	typedef logic signed [ANGLE_W-1:0] sangle_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]     cfg_data_t;
	typedef logic [ACC_W-1:0]          acc_t;

	localparam cfg_idx_t REG_VIEW_ANGLE = 2'd0;
	localparam cfg_idx_t REG_MAX_RANGE  = 2'd1;

	localparam angle_t VIEW_ANGLE_RST = 16'd16384;
	localparam angle_t MAX_RANGE_RST  = 16'd0;

	// Accumulator start values after the quarter-turn pre-rotation, and the rounding offset
	localparam acc_t ACC_PLUS_QUARTER  = 32'h4000_0000;
	localparam acc_t ACC_MINUS_QUARTER = 32'hC000_0000;
	localparam acc_t ACC_ROUND_HALF    = 32'h0000_8000;

	// atan(2^-i) as a 32-bit binary angle, rounded
	localparam acc_t ATAN_TAB [ATAN_DEPTH] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage

@@ rtl/point_sector_filter.sv @@
// Top level of the sector filter: range test, CORDIC bearing pipeline and field-of-view test.
//
// Each beat carries one point and an observer pose; the block answers whether the point lies
// within max_range of the observer and within half of view_angle either side of the heading.
// A new beat may be started in every clock cycle and busy stays low. Each result appears on
// done for exactly one cycle, in start order; the receiver cannot stall the pipeline, so it
// must take every result as it comes. The bearing path runs one CORDIC iteration per
// pipeline stage, with two stages of subtraction and pre-rotation before it and two of
// rounding and comparison after it. Configuration writes take effect at once and should be
// made while no beat is in flight.
module point_sector_filter #(
	parameter int CORDIC_STEPS = 16,
	parameter int COORD_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          wr_en,
	input  psf_pkg::cfg_idx_t             wr_index,
	input  psf_pkg::cfg_data_t            wr_data,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic signed [COORD_BITS-1:0]  origin_x,
	input  logic signed [COORD_BITS-1:0]  origin_y,
	input  psf_pkg::sangle_t              facing,
	input  logic                          final_point,
	output logic                          done,
	output logic                          keep,
	output logic signed [COORD_BITS-1:0]  out_x,
	output logic signed [COORD_BITS-1:0]  out_y,
	output logic                          final_out
);
	import psf_pkg::*;

	localparam int DW  = COORD_BITS + 1;
	localparam int CW  = DW + 2 + CORDIC_STEPS;
	localparam int AW  = (COORD_BITS > ANGLE_W) ? COORD_BITS : ANGLE_W;
	localparam int LAT = CORDIC_STEPS + 4;

	// configuration
	angle_t            view_angle_q;
	angle_t            max_range_q;
	logic [2*ANGLE_W-1:0] range_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_angle_q <= VIEW_ANGLE_RST;
			max_range_q  <= MAX_RANGE_RST;
			range_sq_q   <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_VIEW_ANGLE: view_angle_q <= wr_data;
					REG_MAX_RANGE:  max_range_q  <= wr_data;
					default: ;
				endcase
			end
			range_sq_q <= max_range_q * max_range_q;
		end
	end

	assign busy = 1'b0;

	// stage 1: differences
	logic                 vld_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1;
	sangle_t              face_s1;
	logic                 fin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		dx_s1   <= {point_x[COORD_BITS-1], point_x} - {origin_x[COORD_BITS-1], origin_x};
		dy_s1   <= {point_y[COORD_BITS-1], point_y} - {origin_y[COORD_BITS-1], origin_y};
		px_s1   <= point_x;
		py_s1   <= point_y;
		face_s1 <= facing;
		fin_s1  <= final_point;
	end

	// stage 2: magnitudes, box test and CORDIC pre-rotation
	logic signed [CW-1:0] dx_ext, dy_ext, x_init, y_init;
	acc_t                 z_init;
	logic [DW-1:0]        adx, ady;
	logic [AW-1:0]        ax_w, ay_w;
	logic                 inbox;

	always_comb begin
		dx_ext = {{(CW-DW){dx_s1[DW-1]}}, dx_s1};
		dy_ext = {{(CW-DW){dy_s1[DW-1]}}, dy_s1};
		if (dx_s1[DW-1]) begin
			if (!dy_s1[DW-1]) begin
				x_init = dy_ext;
				y_init = -dx_ext;
				z_init = ACC_PLUS_QUARTER;
			end else begin
				x_init = -dy_ext;
				y_init = dx_ext;
				z_init = ACC_MINUS_QUARTER;
			end
		end else begin
			x_init = dx_ext;
			y_init = dy_ext;
			z_init = '0;
		end
		adx   = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
		ady   = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
		ax_w  = AW'(adx[COORD_BITS-1:0]);
		ay_w  = AW'(ady[COORD_BITS-1:0]);
		inbox = (ax_w <= AW'(max_range_q)) && (ay_w <= AW'(max_range_q));
	end

	// CORDIC line: index 0 is stage 2, index k the output of iteration k-1
	logic                         vld_s  [CORDIC_STEPS+1];
	logic signed [CW-1:0]         cx_s   [CORDIC_STEPS+1];
	logic signed [CW-1:0]         cy_s   [CORDIC_STEPS+1];
	acc_t                         cz_s   [CORDIC_STEPS+1];
	logic signed [COORD_BITS-1:0] px_s   [CORDIC_STEPS+1];
	logic signed [COORD_BITS-1:0] py_s   [CORDIC_STEPS+1];
	sangle_t                      face_s [CORDIC_STEPS+1];
	logic                         fin_s  [CORDIC_STEPS+1];
	logic                         zero_s [CORDIC_STEPS+1];
	logic                         rok_s  [2:CORDIC_STEPS];

	logic [ANGLE_W-1:0]   ax16_s2, ay16_s2;
	logic                 inbox_s2;
	logic [2*ANGLE_W-1:0] sqx_s3, sqy_s3;
	logic                 inbox_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else         vld_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		cx_s[0]   <= x_init <<< CORDIC_STEPS;
		cy_s[0]   <= y_init <<< CORDIC_STEPS;
		cz_s[0]   <= z_init;
		px_s[0]   <= px_s1;
		py_s[0]   <= py_s1;
		face_s[0] <= face_s1;
		fin_s[0]  <= fin_s1;
		zero_s[0] <= (dx_s1 == '0) && (dy_s1 == '0);
		ax16_s2   <= ax_w[ANGLE_W-1:0];
		ay16_s2   <= ay_w[ANGLE_W-1:0];
		inbox_s2  <= inbox;
	end

	// range test runs beside the first two iterations
	always_ff @(posedge clk) begin
		sqx_s3   <= ax16_s2 * ax16_s2;
		sqy_s3   <= ay16_s2 * ay16_s2;
		inbox_s3 <= inbox_s2;
		rok_s[2] <= inbox_s3 &&
			(({1'b0, sqx_s3} + {1'b0, sqy_s3}) <= {1'b0, range_sq_q});
	end

	for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else         vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			// y at or above zero counts as positive: rotate clockwise
			if (!cy_s[k-1][CW-1]) begin
				cx_s[k] <= cx_s[k-1] + (cy_s[k-1] >>> (k-1));
				cy_s[k] <= cy_s[k-1] - (cx_s[k-1] >>> (k-1));
				cz_s[k] <= cz_s[k-1] + ATAN_TAB[k-1];
			end else begin
				cx_s[k] <= cx_s[k-1] - (cy_s[k-1] >>> (k-1));
				cy_s[k] <= cy_s[k-1] + (cx_s[k-1] >>> (k-1));
				cz_s[k] <= cz_s[k-1] - ATAN_TAB[k-1];
			end
			px_s[k]   <= px_s[k-1];
			py_s[k]   <= py_s[k-1];
			face_s[k] <= face_s[k-1];
			fin_s[k]  <= fin_s[k-1];
			zero_s[k] <= zero_s[k-1];
		end

		if (k >= 3) begin : g_rok
			always_ff @(posedge clk) begin
				rok_s[k] <= rok_s[k-1];
			end
		end
	end

	// end stage 1: round the bearing, take its offset from the heading
	acc_t   z_rnd;
	angle_t bearing, rel;
	logic   vld_se1, rok_se1, fin_se1;
	angle_t mag_se1;
	logic signed [COORD_BITS-1:0] px_se1, py_se1;

	always_comb begin
		z_rnd   = cz_s[CORDIC_STEPS] + ACC_ROUND_HALF;
		bearing = zero_s[CORDIC_STEPS] ? '0 : z_rnd[ACC_W-1 -: ANGLE_W];
		rel     = bearing - angle_t'(face_s[CORDIC_STEPS]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_se1 <= 1'b0;
		else         vld_se1 <= vld_s[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		// half a turn maps onto itself, so the negation stays in range
		mag_se1 <= rel[ANGLE_W-1] ? (angle_t'(0) - rel) : rel;
		rok_se1 <= rok_s[CORDIC_STEPS];
		px_se1  <= px_s[CORDIC_STEPS];
		py_se1  <= py_s[CORDIC_STEPS];
		fin_se1 <= fin_s[CORDIC_STEPS];
	end

	// end stage 2: field-of-view compare into the result register
	logic done_q, keep_q, fin_q;
	logic signed [COORD_BITS-1:0] out_x_q, out_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= vld_se1;
	end

	always_ff @(posedge clk) begin
		keep_q  <= rok_se1 && ({mag_se1, 1'b0} <= {1'b0, view_angle_q});
		out_x_q <= px_se1;
		out_y_q <= py_se1;
		fin_q   <= fin_se1;
	end

	assign done      = done_q;
	assign keep      = keep_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign final_out = fin_q;

	// every result strobe stems from a matching start that went through the whole pipeline
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result strobe without matching start");

	// every start yields a result at the end of the pipeline
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("start lost in pipeline");

	// the point travels with its own beat
	a_point_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_x == $past(point_x, LAT)) && (out_y == $past(point_y, LAT)))
		else $error("point coordinates misaligned with result");

endmodule
